// File: hdl/shmh_pkg.sv
// Shared types, constants and round functions for the SHA-256 message hasher.
`default_nettype none

package shmh_pkg;

    // Depth of the word queue between the padding front end and the round engine
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Item moved through the word queue
    typedef struct packed {
        logic [31:0] word;
        logic        msg_end;
    } t_qitem;

    // Front end (padding) states
    typedef enum logic [1:0] {
        FR_IDLE,
        FR_PAD80,
        FR_PAD,
        FR_LENLO
    } t_front_state;

    // Round engine states
    typedef enum logic [1:0] {
        CORE_LOAD,
        CORE_ROUND,
        CORE_FOLD,
        CORE_OUT
    } t_core_state;

    // Padding constants
    localparam logic [31:0] PAD_WORD    = 32'h8000_0000;
    localparam logic [2:0]  FULL_BYTES  = 3'd4;
    localparam logic [3:0]  LEN_HI_SLOT = 4'd14;
    localparam logic [5:0]  FULL_BITS   = 6'd32;
    localparam logic [1:0]  LAST_PART   = 2'd3;

    // Initial hash values
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants
    localparam logic [31:0] K_ROUND [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // Rotate right by a constant amount
    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

// File: hdl/shmh_front.sv
// Front end: accepts message words, applies padding and length, feeds the word queue.
`default_nettype none

module shmh_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [31:0]      i_data_word,
    input  wire logic [2:0]       i_byte_count,
    input  wire logic             i_last,
    output logic                  o_q_push,
    output shmh_pkg::t_qitem      o_q_item,
    input  wire logic             i_q_full
);

    shmh_pkg::t_front_state r_state, n_state;
    logic [3:0]  r_pos;
    logic [63:0] r_len;

    logic        accept;
    logic [2:0]  count_sat;
    logic [4:0]  byte_shift;
    logic [5:0]  len_add;
    logic [31:0] padded_word;

    // Classify the incoming word
    always_comb begin
        count_sat   = (i_byte_count > shmh_pkg::FULL_BYTES) ? shmh_pkg::FULL_BYTES
                                                           : i_byte_count;
        byte_shift  = {count_sat[1:0], 3'b000};
        len_add     = i_last ? {count_sat, 3'b000} : shmh_pkg::FULL_BITS;
        padded_word = (i_data_word & ~(32'hFFFF_FFFF >> byte_shift))
                    | (shmh_pkg::PAD_WORD >> byte_shift);
        accept      = i_in_valid && o_in_ready;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            shmh_pkg::FR_IDLE: begin
                if (accept && i_last) begin
                    n_state = (count_sat == shmh_pkg::FULL_BYTES) ? shmh_pkg::FR_PAD80
                                                                   : shmh_pkg::FR_PAD;
                end
            end
            shmh_pkg::FR_PAD80: begin
                if (!i_q_full) begin
                    n_state = shmh_pkg::FR_PAD;
                end
            end
            shmh_pkg::FR_PAD: begin
                if (!i_q_full && r_pos == shmh_pkg::LEN_HI_SLOT) begin
                    n_state = shmh_pkg::FR_LENLO;
                end
            end
            shmh_pkg::FR_LENLO: begin
                if (!i_q_full) begin
                    n_state = shmh_pkg::FR_IDLE;
                end
            end
            default: n_state = shmh_pkg::FR_IDLE;
        endcase
    end

    // Outputs per state
    always_comb begin
        o_in_ready       = 1'b0;
        o_q_push         = 1'b0;
        o_q_item.word    = '0;
        o_q_item.msg_end = 1'b0;
        case (r_state)
            shmh_pkg::FR_IDLE: begin
                o_in_ready    = !i_q_full;
                o_q_push      = accept;
                o_q_item.word = (!i_last || count_sat == shmh_pkg::FULL_BYTES) ? i_data_word
                                                                                : padded_word;
            end
            shmh_pkg::FR_PAD80: begin
                o_q_push      = !i_q_full;
                o_q_item.word = shmh_pkg::PAD_WORD;
            end
            shmh_pkg::FR_PAD: begin
                o_q_push      = !i_q_full;
                o_q_item.word = (r_pos == shmh_pkg::LEN_HI_SLOT) ? r_len[63:32] : 32'd0;
            end
            shmh_pkg::FR_LENLO: begin
                o_q_push         = !i_q_full;
                o_q_item.word    = r_len[31:0];
                o_q_item.msg_end = 1'b1;
            end
            default: begin
                o_q_push = 1'b0;
            end
        endcase
    end

    // Track slot position and bit length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shmh_pkg::FR_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_len <= r_len + 64'(len_add);
            end
            if (o_q_push) begin
                if (r_state == shmh_pkg::FR_LENLO) begin
                    r_pos <= '0;
                    r_len <= '0;
                end else begin
                    r_pos <= r_pos + 4'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/shmh_queue.sv
// Short word queue between the padding front end and the round engine.
`default_nettype none

module shmh_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire shmh_pkg::t_qitem  i_item,
    output logic                   o_full,
    output logic                   o_valid,
    input  wire logic              i_pop,
    output shmh_pkg::t_qitem       o_item
);

    shmh_pkg::t_qitem r_mem [shmh_pkg::QDEPTH];
    logic [shmh_pkg::QAW-1:0] r_wp;
    logic [shmh_pkg::QAW-1:0] r_rp;
    logic [shmh_pkg::QAW:0]   r_count;

    logic do_push;
    logic do_pop;

    // Status and head of queue
    always_comb begin
        o_full  = (r_count == (shmh_pkg::QAW+1)'(shmh_pkg::QDEPTH));
        o_valid = (r_count != '0);
        o_item  = r_mem[r_rp];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
    end

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/shmh_core.sv
// Round engine: collects 16 words, runs 64 rounds, folds into the chain and emits the digest.
`default_nettype none

module shmh_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    output logic                   o_q_pop,
    input  wire shmh_pkg::t_qitem  i_q_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [63:0]            o_digest_part,
    output logic [1:0]             o_part_index,
    output logic                   o_last_part
);

    shmh_pkg::t_core_state r_state, n_state;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_cnt;
    logic        r_msg_end;
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [1:0]  r_part;

    logic        q_ready;
    logic        out_take;
    logic [31:0] w_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] sum [8];

    // Message schedule, one round and chain fold
    always_comb begin
        w_next = r_w[0] + shmh_pkg::small_sigma0(r_w[1]) + r_w[9]
               + shmh_pkg::small_sigma1(r_w[14]);
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + shmh_pkg::big_sigma1(r_v[4]) + ch
               + shmh_pkg::K_ROUND[r_cnt] + r_w[0];
        t2     = shmh_pkg::big_sigma0(r_v[0]) + maj;
        for (int i = 0; i < 8; i++) begin
            sum[i] = r_h[i] + r_v[i];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            shmh_pkg::CORE_LOAD: begin
                if (i_q_valid && r_cnt[3:0] == 4'd15) begin
                    n_state = shmh_pkg::CORE_ROUND;
                end
            end
            shmh_pkg::CORE_ROUND: begin
                if (r_cnt == 6'd63) begin
                    n_state = shmh_pkg::CORE_FOLD;
                end
            end
            shmh_pkg::CORE_FOLD: begin
                n_state = r_msg_end ? shmh_pkg::CORE_OUT : shmh_pkg::CORE_LOAD;
            end
            shmh_pkg::CORE_OUT: begin
                if (out_take && r_part == shmh_pkg::LAST_PART) begin
                    n_state = shmh_pkg::CORE_LOAD;
                end
            end
            default: n_state = shmh_pkg::CORE_LOAD;
        endcase
    end

    // Outputs per state
    always_comb begin
        q_ready = 1'b0;
        case (r_state)
            shmh_pkg::CORE_LOAD: q_ready = 1'b1;
            default:             q_ready = 1'b0;
        endcase
        o_q_pop       = q_ready && i_q_valid;
        out_take      = r_out_valid && i_out_ready;
        o_out_valid   = r_out_valid;
        o_digest_part = r_out_data;
        o_part_index  = r_part;
        o_last_part   = (r_part == shmh_pkg::LAST_PART);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shmh_pkg::CORE_LOAD;
            r_cnt       <= '0;
            r_msg_end   <= 1'b0;
            r_out_valid <= 1'b0;
            r_part      <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= shmh_pkg::IV[i];
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                shmh_pkg::CORE_LOAD: begin
                    if (o_q_pop) begin
                        r_cnt     <= (r_cnt[3:0] == 4'd15) ? 6'd0 : r_cnt + 6'd1;
                        r_msg_end <= r_msg_end | i_q_item.msg_end;
                    end
                end
                shmh_pkg::CORE_ROUND: begin
                    r_cnt <= r_cnt + 6'd1;
                end
                shmh_pkg::CORE_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= sum[i];
                    end
                    if (r_msg_end) begin
                        r_out_valid <= 1'b1;
                        r_part      <= '0;
                    end
                end
                shmh_pkg::CORE_OUT: begin
                    if (out_take) begin
                        if (r_part == shmh_pkg::LAST_PART) begin
                            // digest delivered: back to the initial chain
                            r_out_valid <= 1'b0;
                            r_msg_end   <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= shmh_pkg::IV[i];
                            end
                        end else begin
                            r_part <= r_part + 2'd1;
                            for (int i = 0; i < 6; i++) begin
                                r_h[i] <= r_h[i+2];
                            end
                        end
                    end
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            shmh_pkg::CORE_LOAD: begin
                if (o_q_pop) begin
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i+1];
                    end
                    r_w[15] <= i_q_item.word;
                    if (r_cnt[3:0] == 4'd15) begin
                        for (int i = 0; i < 8; i++) begin
                            r_v[i] <= r_h[i];
                        end
                    end
                end
            end
            shmh_pkg::CORE_ROUND: begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_next;
                r_v[7]  <= r_v[6];
                r_v[6]  <= r_v[5];
                r_v[5]  <= r_v[4];
                r_v[4]  <= r_v[3] + t1;
                r_v[3]  <= r_v[2];
                r_v[2]  <= r_v[1];
                r_v[1]  <= r_v[0];
                r_v[0]  <= t1 + t2;
            end
            shmh_pkg::CORE_FOLD: begin
                r_out_data <= {sum[0], sum[1]};
            end
            shmh_pkg::CORE_OUT: begin
                if (out_take) begin
                    r_out_data <= {r_h[2], r_h[3]};
                end
            end
            default: begin
                r_out_data <= r_out_data;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/sha256_message_hasher_unit.sv
// Top level of the SHA-256 message hasher: front end, word queue and round engine.
//
// Input channel (i_in_valid / o_in_ready): one 32-bit big-endian message word per item,
// i_byte_count valid leading bytes (honored only with i_last), i_last on the final word.
// Output channel (o_out_valid / i_out_ready): after a final word, four items carry the
// 256-bit digest as 64-bit parts, part 0 first, o_last_part set on part 3.
// Each 16-word block is loaded word by word, run through 64 rounds and folded into the chain;
// the single round unit takes no words of the next block while it runs the rounds and the fold.
// Non-final words pass through the front end at one per cycle into a 4-entry queue and
// stall only when that queue is full or the front end is still padding a message.
// After a final word the front end is busy generating padding and the bit length;
// the first digest part is valid once the round engine has taken the last padding word
// and run the 64 rounds and the fold; the rest follow one per cycle while i_out_ready is high.
// While the receiver stalls, the current digest part is held and the round engine waits;
// the front end keeps accepting words of the next message until the queue fills.
// Reset (i_rst_n low, synchronous) empties the queue, clears position and length,
// and loads the standard initial hash values.
`default_nettype none

module sha256_message_hasher_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_digest_part,
    output logic [1:0]       o_part_index,
    output logic             o_last_part
);

    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    shmh_pkg::t_qitem q_in_item;
    shmh_pkg::t_qitem q_out_item;

    // Padding front end
    shmh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .o_q_push     (q_push),
        .o_q_item     (q_in_item),
        .i_q_full     (q_full)
    );

    // Word queue
    shmh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_out_item)
    );

    // Round engine
    shmh_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_item      (q_out_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_part (o_digest_part),
        .o_part_index  (o_part_index),
        .o_last_part   (o_last_part)
    );

    // A final word always starts padding, so the front end is busy the next cycle
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last |=> !o_in_ready)
        else $error("input accepted right after a final word");

    // Digest parts advance in order
    a_part_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_part |=>
            o_out_valid && (o_part_index == $past(o_part_index) + 2'd1))
        else $error("digest part out of order");

    // After the final part the output goes idle
    a_idle_after_digest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_last_part |=> !o_out_valid)
        else $error("extra digest part after the final one");

    // The queue is never pushed while full
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("word queue overflow");

endmodule

`default_nettype wire

// File: test/sha256_message_hasher_unit_test.sv
// Self-checking testbench for the SHA-256 message hasher: directed vectors, then random messages.
`default_nettype none

module sha256_message_hasher_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 300;
    localparam int TOTAL_ITEMS  = 110;

    localparam logic [1:0]  FINAL_PART = 2'd3;
    localparam logic [2:0]  WORD_BYTES = 3'd4;
    localparam logic [3:0]  LEN_SLOT   = 4'd14;
    localparam logic [31:0] PAD_MARK   = 32'h8000_0000;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RK [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    typedef struct {
        logic [63:0] part;
        logic [1:0]  index;
        logic        final_flag;
    } t_digest_part;

    typedef struct {
        logic [31:0]  word;
        logic [2:0]   nbytes;
        logic         lst;
        bit           known;
        logic [255:0] golden;
    } t_vector;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [31:0] i_data_word  = '0;
    logic [2:0]  i_byte_count = '0;
    logic        i_last       = 1'b0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_digest_part;
    logic [1:0]  o_part_index;
    logic        o_last_part;

    // Digest parts still owed by the block, oldest first
    t_digest_part digest_q[$];
    t_vector      directed[$];

    // Hash state of the predictor
    logic [31:0] chain [8];
    logic [31:0] blk [16];
    logic [3:0]  word_slot;
    logic [63:0] msg_bits;

    int  errors        = 0;
    int  words_sent    = 0;
    int  msgs_sent     = 0;
    int  parts_checked = 0;
    int  stall_cycles  = 0;
    bit  hold_armed    = 1'b0;
    bit  hold_done     = 1'b0;

    sha256_message_hasher_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_part (o_digest_part),
        .o_part_index  (o_part_index),
        .o_last_part   (o_last_part)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        logic [63:0] xx;
        xx = {x, x} >> n;
        return xx[31:0];
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) chain[i] = HASH_INIT[i];
        word_slot = '0;
        msg_bits  = '0;
    endfunction

    // Run 64 rounds over the buffered block and fold into the chain
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++) w[t] = blk[t];
        for (int t = 16; t < 64; t++) begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function automatic void store_word(input logic [31:0] w);
        blk[word_slot] = w;
        word_slot = word_slot + 4'd1;
        if (word_slot == 4'd0) compress_block();
    endfunction

    // Absorb one word; on the final word pad, finish and return the digest
    function automatic bit hash_word(input logic [31:0] w, input logic [2:0] nb,
                                     input logic lst, output logic [255:0] dg);
        logic [2:0]  n;
        logic [31:0] mask;
        dg = '0;
        if (!lst) begin
            msg_bits = msg_bits + 64'd32;
            store_word(w);
            return 1'b0;
        end
        n = (nb > WORD_BYTES) ? WORD_BYTES : nb;
        msg_bits = msg_bits + {58'd0, n, 3'd0};
        if (n < WORD_BYTES) begin
            mask = ~(32'hFFFF_FFFF >> (8 * n));
            store_word((w & mask) | (PAD_MARK >> (8 * n)));
        end else begin
            store_word(w);
            store_word(PAD_MARK);
        end
        while (word_slot != LEN_SLOT) store_word('0);
        store_word(msg_bits[63:32]);
        store_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++) dg[255 - 32 * i -: 32] = chain[i];
        restart_hash();
        return 1'b1;
    endfunction

    // Offer one item, hold it until accepted, then queue any digest it completes
    task automatic send_item(input logic [31:0] w, input logic [2:0] nb, input logic lst,
                             input bit known, input logic [255:0] golden);
        logic [255:0] dg;
        t_digest_part p;
        i_in_valid   <= 1'b1;
        i_data_word  <= w;
        i_byte_count <= nb;
        i_last       <= lst;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
        if (hash_word(w, nb, lst, dg)) begin
            if (known) dg = golden;
            for (int k = 0; k < 4; k++) begin
                p.part       = dg[255 - 64 * k -: 64];
                p.index      = 2'(k);
                p.final_flag = (2'(k) == FINAL_PART);
                digest_q.push_back(p);
            end
            msgs_sent++;
        end
    endtask

    // Drop valid for a random gap: mostly none or short, now and then long
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60) n = 0;
        else if (r < 92) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Sender: reset, directed table, random messages, drain
    initial begin : sender
        int  len;
        int  r;
        bit  burst;
        restart_hash();

        directed.push_back(t_vector'{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST});
        directed.push_back(t_vector'{32'h6162_63FF, 3'd3, 1'b1, 1'b1, ABC_DIGEST});
        directed.push_back(t_vector'{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, '0});
        directed.push_back(t_vector'{32'h0000_0000, 3'd4, 1'b1, 1'b0, '0});
        directed.push_back(t_vector'{32'h1234_5678, 3'd1, 1'b1, 1'b0, '0});
        directed.push_back(t_vector'{32'h8765_4321, 3'd2, 1'b1, 1'b0, '0});
        // Fourteen full words push the pad marker into slot 14: two final blocks
        for (int i = 0; i < 14; i++)
            directed.push_back(t_vector'{(i % 2 == 0) ? 32'hFFFF_FFFF : 32'(i) * 32'h0101_0101,
                                         3'(i), 1'b0, 1'b0, '0});
        directed.push_back(t_vector'{32'hDEAD_BEEF, 3'd0, 1'b1, 1'b0, '0});
        // Byte count on non-final words is ignored
        directed.push_back(t_vector'{32'h0102_0304, 3'd0, 1'b0, 1'b0, '0});
        directed.push_back(t_vector'{32'hCAFE_F00D, 3'd5, 1'b0, 1'b0, '0});
        directed.push_back(t_vector'{32'h0BAD_F00D, 3'd4, 1'b1, 1'b0, '0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send_item(directed[i].word, directed[i].nbytes, directed[i].lst,
                      directed[i].known, directed[i].golden);
            idle_gap();
        end

        // Random messages; the receiver takes one long hold early in this part
        hold_armed = 1'b1;
        while (words_sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(0, 15);
            else if (r < 92) len = $urandom_range(16, 31);
            else len = $urandom_range(32, 48);
            // Keep the whole run near the planned item count
            if (len > TOTAL_ITEMS - words_sent - 1) len = TOTAL_ITEMS - words_sent - 1;
            burst = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < len; j++) begin
                send_item($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
                if (!burst) idle_gap();
            end
            send_item($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
            idle_gap();
        end
        i_in_valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages from %0d words; %0d digest parts checked.",
                 msgs_sent, words_sent, parts_checked);
        $display("Receiver hold with full input queue %s.", hold_done ? "done" : "not reached");
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Receiver: random stalls, calm stretches, one long hold
    initial begin : receiver
        int  stall_left;
        int  phase_left;
        bit  calm;
        stall_left = 0;
        phase_left = $urandom_range(50, 300);
        calm       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && o_out_valid) begin
                hold_armed = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                              : $urandom_range(10, 40);
            end
            phase_left--;
            if (phase_left == 0) begin
                calm       = !calm;
                phase_left = $urandom_range(50, 300);
            end
        end
    end

    // Compare each accepted digest part with the oldest one owed
    always @(posedge i_clk) begin : check_digest
        t_digest_part want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: digest part with none expected: part %h index %0d last %b",
                         $time, o_digest_part, o_part_index, o_last_part);
                errors++;
            end else begin
                want = digest_q.pop_front();
                parts_checked++;
                if (o_digest_part !== want.part) begin
                    $display("%0t: digest_part expected %h actual %h",
                             $time, want.part, o_digest_part);
                    errors++;
                end
                if (o_part_index !== want.index) begin
                    $display("%0t: part_index expected %0d actual %0d",
                             $time, want.index, o_part_index);
                    errors++;
                end
                if (o_last_part !== want.final_flag) begin
                    $display("%0t: last_part expected %b actual %b",
                             $time, want.final_flag, o_last_part);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

`default_nettype wire
